[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/tesp_pkg.sv]
// ----------------------------------------------------------------------------
// tesp_pkg
// Types, constants and helpers for the tree entry stream parser.
// ----------------------------------------------------------------------------
package tesp_pkg;

    localparam int HASH_BYTES = 20;
    localparam int MODE_BITS  = 64;
    localparam int HASH_CNT_W = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;
    localparam int RUN_MAX    = 3;

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGN,
        PH_DIGITS,
        PH_PATH,
        PH_HASH,
        PH_SWALLOW
    } phase_t;

    localparam logic [2:0] KIND_MODE  = 3'd0;
    localparam logic [2:0] KIND_PATH  = 3'd1;
    localparam logic [2:0] KIND_HASH  = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [1:0]  error_code;
        logic        run_last;
    } out_item_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic out_item_t make_item(input logic [2:0] kind,
                                            input logic [63:0] value,
                                            input logic [1:0] err);
        out_item_t r;
        r.kind       = kind;
        r.value      = value;
        r.error_code = err;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

[rtl/tree_entry_stream_parser_unit.sv]
// ----------------------------------------------------------------------------
// tree_entry_stream_parser_unit
// Parses tree entries (octal mode, space, path, raw hash) from a byte stream.
// ----------------------------------------------------------------------------
// Results of a byte come from the input register via the result buffer.
// Throughput: one byte per cycle while each byte gives at most one result
// and results are not stalled; after a byte with two or three results,
// the next result-giving byte waits for the three-slot buffer's last pop.
// Reset: asynchronous, active low; parser returns to leading whitespace.
module tree_entry_stream_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tesp_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output tesp_pkg::out_item_t result
);

    localparam int MB = tesp_pkg::MODE_BITS;
    localparam int HW = tesp_pkg::HASH_CNT_W;

    logic                 in_valid_reg;
    tesp_pkg::in_item_t   in_item_reg;

    tesp_pkg::phase_t     phase_reg, phase_next;
    logic [MB-1:0]        acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 ovf_reg, ovf_next;
    logic [HW-1:0]        hc_reg, hc_next;

    tesp_pkg::out_item_t  slot_reg [tesp_pkg::RUN_MAX];
    logic [1:0]           cnt_reg;

    tesp_pkg::out_item_t  res [tesp_pkg::RUN_MAX];
    logic [1:0]           n;
    logic                 finished;
    logic                 fail_now;
    logic [1:0]           fail_code;
    logic [1:0]           err_code;
    logic [7:0]           b;
    logic                 last;
    logic                 dig_ovf;
    logic [MB-1:0]        dig_acc;
    logic [MB-1:0]        acc_neg;
    logic [63:0]          mode_value;
    logic                 pop;
    logic                 consume;
    logic                 load;

    assign b    = in_item_reg.data_byte;
    assign last = in_item_reg.last_byte;

    assign dig_ovf = ovf_reg | (|acc_reg[MB-1 -: 3]);
    assign dig_acc = dig_ovf ? acc_reg : {acc_reg[MB-4:0], b[2:0]};
    assign acc_neg = '0 - acc_reg;
    assign mode_value = 64'(neg_reg ? acc_neg : acc_reg);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        hc_next    = hc_reg;
        for (int i = 0; i < tesp_pkg::RUN_MAX; i++)
        begin
            res[i] = '0;
        end
        n         = 2'd0;
        finished  = 1'b0;
        fail_now  = 1'b0;
        fail_code = tesp_pkg::ERR_MALFORMED;
        err_code  = tesp_pkg::ERR_MALFORMED;

        unique case (phase_reg)
            tesp_pkg::PH_SWALLOW:
            begin
                finished = 1'b1;
                if (last)
                begin
                    phase_next = tesp_pkg::PH_WS;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    ovf_next   = 1'b0;
                    hc_next    = '0;
                end
            end
            tesp_pkg::PH_WS:
            begin
                if (tesp_pkg::is_ws(b))
                begin
                end
                else if (b == tesp_pkg::CH_PLUS)
                begin
                    phase_next = tesp_pkg::PH_SIGN;
                end
                else if (b == tesp_pkg::CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = tesp_pkg::PH_SIGN;
                end
                else if (tesp_pkg::is_oct(b))
                begin
                    acc_next   = dig_acc;
                    ovf_next   = dig_ovf;
                    phase_next = tesp_pkg::PH_DIGITS;
                end
                else
                begin
                    fail_now = 1'b1;
                end
            end
            tesp_pkg::PH_SIGN:
            begin
                if (tesp_pkg::is_oct(b))
                begin
                    acc_next   = dig_acc;
                    ovf_next   = dig_ovf;
                    phase_next = tesp_pkg::PH_DIGITS;
                end
                else
                begin
                    fail_now = 1'b1;
                end
            end
            tesp_pkg::PH_DIGITS:
            begin
                if (tesp_pkg::is_oct(b))
                begin
                    acc_next = dig_acc;
                    ovf_next = dig_ovf;
                end
                else if (b == tesp_pkg::CH_SPACE && !ovf_reg)
                begin
                    res[n] = tesp_pkg::make_item(tesp_pkg::KIND_MODE, mode_value,
                                                 tesp_pkg::ERR_NONE);
                    n = n + 2'd1;
                    phase_next = tesp_pkg::PH_PATH;
                end
                else
                begin
                    fail_now  = 1'b1;
                    fail_code = ovf_reg ? tesp_pkg::ERR_OVERFLOW : tesp_pkg::ERR_MALFORMED;
                end
            end
            tesp_pkg::PH_PATH:
            begin
                if (b != tesp_pkg::CH_NUL)
                begin
                    res[n] = tesp_pkg::make_item(tesp_pkg::KIND_PATH, 64'(b),
                                                 tesp_pkg::ERR_NONE);
                    n = n + 2'd1;
                end
                else
                begin
                    hc_next    = '0;
                    phase_next = tesp_pkg::PH_HASH;
                end
            end
            tesp_pkg::PH_HASH:
            begin
                res[n] = tesp_pkg::make_item(tesp_pkg::KIND_HASH, 64'(b),
                                             tesp_pkg::ERR_NONE);
                n = n + 2'd1;
                if (hc_reg == HW'(tesp_pkg::HASH_BYTES - 1))
                begin
                    res[n] = tesp_pkg::make_item(tesp_pkg::KIND_END, '0,
                                                 tesp_pkg::ERR_NONE);
                    n = n + 2'd1;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    ovf_next   = 1'b0;
                    hc_next    = '0;
                    phase_next = tesp_pkg::PH_WS;
                    if (last)
                    begin
                        res[n] = tesp_pkg::make_item(tesp_pkg::KIND_DONE, '0,
                                                     tesp_pkg::ERR_NONE);
                        n = n + 2'd1;
                    end
                    finished = 1'b1;
                end
                else
                begin
                    hc_next = HW'(hc_reg + 1'b1);
                end
            end
            default:
            begin
                fail_now = 1'b1;
            end
        endcase

        if (fail_now || (last && !finished))
        begin
            err_code = fail_now ? fail_code
                     : (ovf_next ? tesp_pkg::ERR_OVERFLOW : tesp_pkg::ERR_MALFORMED);
            res[n] = tesp_pkg::make_item(tesp_pkg::KIND_ERROR, '0, err_code);
            n = n + 2'd1;
            acc_next   = '0;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            hc_next    = '0;
            phase_next = last ? tesp_pkg::PH_WS : tesp_pkg::PH_SWALLOW;
        end

        if (n != 2'd0)
        begin
            res[n - 2'd1].run_last = 1'b1;
        end
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = slot_reg[0];
    assign pop          = result_valid && !result_stall;
    assign consume      = in_valid_reg &&
                          ((n == 2'd0) || (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop));
    assign load         = consume && (n != 2'd0);
    assign item_stall   = in_valid_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= tesp_pkg::PH_WS;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            hc_reg       <= '0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (!in_valid_reg || consume)
            begin
                in_valid_reg <= item_valid;
            end
            if (consume)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                ovf_reg   <= ovf_next;
                hc_reg    <= hc_next;
            end
            if (load)
            begin
                cnt_reg <= n;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_valid_reg || consume)
        begin
            in_item_reg <= item;
        end
        if (load)
        begin
            for (int i = 0; i < tesp_pkg::RUN_MAX; i++)
            begin
                slot_reg[i] <= res[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < tesp_pkg::RUN_MAX - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

endmodule

[rtl/tesp_checker.sv]
// ----------------------------------------------------------------------------
// tesp_checker
// Port-level checks on both channels of the tree entry stream parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tesp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input tesp_pkg::in_item_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input tesp_pkg::out_item_t result
);

    `ASSERT_NEXT(a_item_hold, clk, rst_n, item_valid && item_stall, item_valid && $stable(item))
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `ASSERT_IMPL(a_err_only_on_error, clk, rst_n, result_valid && (result.kind != tesp_pkg::KIND_ERROR), result.error_code == tesp_pkg::ERR_NONE)
    `ASSERT_IMPL(a_marks_zero_value, clk, rst_n, result_valid && (result.kind == tesp_pkg::KIND_END || result.kind == tesp_pkg::KIND_DONE || result.kind == tesp_pkg::KIND_ERROR), result.value == 64'd0)
    `ASSERT_IMPL(a_done_ends_run, clk, rst_n, result_valid && (result.kind == tesp_pkg::KIND_DONE || result.kind == tesp_pkg::KIND_ERROR), result.run_last)

endmodule

bind tree_entry_stream_parser_unit tesp_checker u_tesp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[sim/tree_entry_stream_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// tree_entry_stream_parser_unit_test
// Streams tree payloads byte by byte through the parser and checks each
// result item against a cycle-free model of the entry grammar. The stimulus
// has short directed payloads, then random ones: clean, truncated,
// corrupted, mode-only and noise. Both sides idle and stall at random, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_entry_stream_parser_unit_test;

    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 12;
    localparam int MODE_DIGITS  = (tesp_pkg::MODE_BITS + 2) / 3;
    localparam logic [63:0] MODE_MASK = {64{1'b1}} >> (64 - tesp_pkg::MODE_BITS);

    class parse_result_tracker;
        tesp_pkg::phase_t    phase;
        logic [63:0]         accum;
        bit                  negative;
        bit                  overflowed;
        int unsigned         hash_seen;
        tesp_pkg::out_item_t step_results[$];
        tesp_pkg::out_item_t pending_results[$];
        int unsigned         mismatch_count;
        int unsigned         results_checked;
        int unsigned         bytes_taken;
        int unsigned         entries_closed;
        int unsigned         payloads_done;
        int unsigned         malformed_count;
        int unsigned         overflow_count;

        function new();
            phase = tesp_pkg::PH_WS;
            restart_entry();
        endfunction

        function void restart_entry();
            accum      = '0;
            negative   = 1'b0;
            overflowed = 1'b0;
            hash_seen  = 0;
        endfunction

        function bit ws_byte(input logic [7:0] b);
            return (b == tesp_pkg::CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function bit octal_byte(input logic [7:0] b);
            return (b >= 8'h30) && (b <= 8'h37);
        endfunction

        function void post(input logic [2:0] kind, input logic [63:0] val,
                           input logic [1:0] code);
            tesp_pkg::out_item_t r;
            r.kind       = kind;
            r.value      = val;
            r.error_code = code;
            r.run_last   = 1'b0;
            step_results.push_back(r);
        endfunction

        function void raise_error(input logic [1:0] code, input bit last);
            post(tesp_pkg::KIND_ERROR, '0, code);
            restart_entry();
            if (last)
                phase = tesp_pkg::PH_WS;
            else
                phase = tesp_pkg::PH_SWALLOW;
        endfunction

        function void take_digit(input logic [7:0] b);
            if (!overflowed)
            begin
                if (accum > (MODE_MASK >> 3))
                    overflowed = 1'b1;
                else
                    accum = (accum << 3) | {61'd0, b[2:0]};
            end
        endfunction

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

        // accepted input byte: work out the results it causes
        function void absorb_byte(input tesp_pkg::in_item_t it);
            logic [7:0] b;
            bit         last;
            bit         closed;
            b      = it.data_byte;
            last   = it.last_byte;
            closed = 1'b0;
            step_results.delete();
            bytes_taken++;
            case (phase)
                tesp_pkg::PH_SWALLOW:
                begin
                    closed = 1'b1;
                    if (last)
                    begin
                        phase = tesp_pkg::PH_WS;
                        restart_entry();
                    end
                end
                tesp_pkg::PH_WS:
                begin
                    if (!ws_byte(b))
                    begin
                        if (b == tesp_pkg::CH_PLUS)
                        begin
                            phase = tesp_pkg::PH_SIGN;
                        end
                        else if (b == tesp_pkg::CH_MINUS)
                        begin
                            negative = 1'b1;
                            phase    = tesp_pkg::PH_SIGN;
                        end
                        else if (octal_byte(b))
                        begin
                            take_digit(b);
                            phase = tesp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            raise_error(tesp_pkg::ERR_MALFORMED, last);
                            closed = 1'b1;
                        end
                    end
                end
                tesp_pkg::PH_SIGN:
                begin
                    if (octal_byte(b))
                    begin
                        take_digit(b);
                        phase = tesp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        raise_error(tesp_pkg::ERR_MALFORMED, last);
                        closed = 1'b1;
                    end
                end
                tesp_pkg::PH_DIGITS:
                begin
                    if (octal_byte(b))
                    begin
                        take_digit(b);
                    end
                    else if (b == tesp_pkg::CH_SPACE && !overflowed)
                    begin
                        post(tesp_pkg::KIND_MODE,
                             negative ? ((~accum + 64'd1) & MODE_MASK) : accum,
                             tesp_pkg::ERR_NONE);
                        phase = tesp_pkg::PH_PATH;
                    end
                    else
                    begin
                        raise_error(overflowed ? tesp_pkg::ERR_OVERFLOW
                                               : tesp_pkg::ERR_MALFORMED, last);
                        closed = 1'b1;
                    end
                end
                tesp_pkg::PH_PATH:
                begin
                    if (b != tesp_pkg::CH_NUL)
                    begin
                        post(tesp_pkg::KIND_PATH, {56'd0, b}, tesp_pkg::ERR_NONE);
                    end
                    else
                    begin
                        hash_seen = 0;
                        phase     = tesp_pkg::PH_HASH;
                    end
                end
                tesp_pkg::PH_HASH:
                begin
                    post(tesp_pkg::KIND_HASH, {56'd0, b}, tesp_pkg::ERR_NONE);
                    if (hash_seen + 1 >= tesp_pkg::HASH_BYTES)
                    begin
                        post(tesp_pkg::KIND_END, '0, tesp_pkg::ERR_NONE);
                        restart_entry();
                        phase = tesp_pkg::PH_WS;
                        if (last)
                            post(tesp_pkg::KIND_DONE, '0, tesp_pkg::ERR_NONE);
                        closed = 1'b1;
                    end
                    else
                    begin
                        hash_seen++;
                    end
                end
                default:
                begin
                    phase = tesp_pkg::PH_WS;
                    restart_entry();
                    raise_error(tesp_pkg::ERR_MALFORMED, last);
                    closed = 1'b1;
                end
            endcase
            if (last && !closed)
                raise_error(overflowed ? tesp_pkg::ERR_OVERFLOW
                                       : tesp_pkg::ERR_MALFORMED, 1'b1);
            if (step_results.size() > 0)
                step_results[step_results.size() - 1].run_last = 1'b1;
            foreach (step_results[i])
            begin
                case (step_results[i].kind)
                    tesp_pkg::KIND_END:   entries_closed++;
                    tesp_pkg::KIND_DONE:  payloads_done++;
                    tesp_pkg::KIND_ERROR:
                    begin
                        if (step_results[i].error_code == tesp_pkg::ERR_OVERFLOW)
                            overflow_count++;
                        else
                            malformed_count++;
                    end
                    default: ;
                endcase
                pending_results.push_back(step_results[i]);
            end
        endfunction

        function void check_result(input tesp_pkg::out_item_t got);
            tesp_pkg::out_item_t want;
            bit                  bad;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected result: kind %0d value %0h", got.kind, got.value);
                return;
            end
            want = pending_results.pop_front();
            bad  = 1'b0;
            if (got.kind !== want.kind)
            begin
                bad = 1'b1;
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            end
            if (got.value !== want.value)
            begin
                bad = 1'b1;
                $error("value: expected %0h, actual %0h", want.value, got.value);
            end
            if (got.error_code !== want.error_code)
            begin
                bad = 1'b1;
                $error("error_code: expected %0d, actual %0d",
                       want.error_code, got.error_code);
            end
            if (got.run_last !== want.run_last)
            begin
                bad = 1'b1;
                $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
            end
            if (bad)
                mismatch_count++;
        endfunction
    endclass

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    tesp_pkg::in_item_t  item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    tesp_pkg::out_item_t result;

    parse_result_tracker book = new();

    tesp_pkg::in_item_t stim_q[$];
    logic [7:0]         payload_q[$];
    int                 recv_stall_pct = 0;
    bit                 hold_request   = 1'b0;
    int                 hold_left      = 0;
    int                 quiet_cycles   = 0;

    tree_entry_stream_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] ws_pick();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? tesp_pkg::CH_SPACE : 8'(9 + r);
    endfunction

    function automatic logic [7:0] octal_pick(input int lo);
        return 8'(8'h30 + $urandom_range(7, lo));
    endfunction

    task automatic flush_payload();
        tesp_pkg::in_item_t it;
        foreach (payload_q[i])
        begin
            it.data_byte = payload_q[i];
            it.last_byte = (i == payload_q.size() - 1);
            stim_q.push_back(it);
        end
        payload_q.delete();
    endtask

    task automatic append_mode();
        int style;
        repeat (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0)
            payload_q.push_back(ws_pick());
        case ($urandom_range(3))
            0:       payload_q.push_back(tesp_pkg::CH_PLUS);
            1:       payload_q.push_back(tesp_pkg::CH_MINUS);
            default: ;
        endcase
        style = $urandom_range(9);
        if (style == 0)
        begin
            // largest mode that still fits
            payload_q.push_back(8'(8'h30 +
                ((1 << (tesp_pkg::MODE_BITS - 3 * (MODE_DIGITS - 1))) - 1)));
            repeat (MODE_DIGITS - 1) payload_q.push_back(8'h37);
        end
        else if (style <= 2)
        begin
            payload_q.push_back(octal_pick(1));
            repeat (MODE_DIGITS + $urandom_range(1)) payload_q.push_back(octal_pick(0));
        end
        else if (style == 3)
        begin
            repeat (MODE_DIGITS) payload_q.push_back(octal_pick(0));
        end
        else
        begin
            repeat ($urandom_range(7, 1)) payload_q.push_back(octal_pick(0));
        end
    endtask

    task automatic append_entry();
        append_mode();
        payload_q.push_back(tesp_pkg::CH_SPACE);
        repeat ($urandom_range(5)) payload_q.push_back(8'($urandom_range(255, 1)));
        payload_q.push_back(tesp_pkg::CH_NUL);
        repeat (tesp_pkg::HASH_BYTES) payload_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_directed();
        // negative mode wrapping to all ones, empty path, hash extremes
        payload_q.push_back(tesp_pkg::CH_MINUS);
        payload_q.push_back(8'h31);
        payload_q.push_back(tesp_pkg::CH_SPACE);
        payload_q.push_back(tesp_pkg::CH_NUL);
        payload_q.push_back(8'h00);
        payload_q.push_back(8'hFF);
        repeat (tesp_pkg::HASH_BYTES - 2) payload_q.push_back(8'($urandom_range(255)));
        flush_payload();
        // no digit on the final byte
        payload_q.push_back(8'hFF);
        flush_payload();
        // bad terminator, then a swallowed byte
        payload_q.push_back(8'h09);
        payload_q.push_back(tesp_pkg::CH_PLUS);
        payload_q.push_back(8'h37);
        payload_q.push_back(8'h71);
        payload_q.push_back(8'h62);
        flush_payload();
    endtask

    task automatic add_random_payload(output int counted);
        int pick;
        int cut;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            repeat ($urandom_range(6, 1)) payload_q.push_back(8'($urandom_range(255)));
        end
        else if (pick < 24)
        begin
            append_mode();
            case ($urandom_range(2))
                0:       payload_q.push_back(tesp_pkg::CH_SPACE);
                1:       payload_q.push_back(8'($urandom_range(255)));
                default: ;
            endcase
        end
        else
        begin
            repeat (($urandom_range(9) < 7) ? 1 : $urandom_range(3, 2)) append_entry();
            if (pick < 38)
            begin
                cut = $urandom_range(payload_q.size() - 1, 1);
                while (payload_q.size() > cut)
                    void'(payload_q.pop_back());
            end
            else if (pick < 48)
            begin
                payload_q[$urandom_range(payload_q.size() - 1)] = 8'($urandom_range(255));
            end
        end
        counted = payload_q.size();
        flush_payload();
    endtask

    task automatic send_item(input tesp_pkg::in_item_t it, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        book.absorb_byte(it);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            book.check_result(result);
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int counted;
        int total;
        int n;
        int send_idle_pct;
        add_directed();
        total = stim_q.size();
        while (total < RANDOM_ITEMS)
        begin
            add_random_payload(counted);
            total += counted;
        end
        n = stim_q.size();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_q[i])
        begin
            if (i < n / 3)
            begin
                send_idle_pct  = 20;
                recv_stall_pct = 50;
            end
            else if (i < 2 * n / 3)
            begin
                send_idle_pct  = 50;
                recv_stall_pct = 20;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (i == 2 * n / 3)
                hold_request = 1'b1;
            send_item(stim_q[i], send_idle_pct);
        end
        item_valid <= 1'b0;
        while (book.pending_count() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d bytes, %0d entries, %0d completed payloads, %0d results.",
                 book.bytes_taken, book.entries_closed, book.payloads_done,
                 book.results_checked);
        $display("Faults raised: %0d malformed or truncated, %0d mode overflow.",
                 book.malformed_count, book.overflow_count);
        if (book.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tesp_pkg.sv
rtl/tree_entry_stream_parser_unit.sv
rtl/tesp_checker.sv
sim/tree_entry_stream_parser_unit_test.sv
